// ===== rtl/grid_sparse_neighbour_counter_defines.svh =====
// Assertion macros used by the checker file of the grid sparse neighbour counter.
`ifndef GRID_SPARSE_NEIGHBOUR_COUNTER_DEFINES_SVH
`define GRID_SPARSE_NEIGHBOUR_COUNTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GSNC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define GSNC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");

`endif

// ===== rtl/gsnc_pkg.sv =====
// Package: constants, register codes and the cell judging function of the neighbour counter.
package gsnc_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_TOTAL_BITS = 24;

	localparam int CELL_BITS       = 8;
	localparam int OUT_BITS        = 24;
	localparam int ROW_WIDTH_BITS  = 9;
	localparam int LIMIT_BITS      = 4;
	localparam int CFG_INDEX_BITS  = 4;
	localparam int CFG_DATA_BITS   = 9;
	localparam int WIN_BITS        = 9;

	localparam logic [CELL_BITS-1:0] OCCUPIED_CHAR = 8'h40;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH       = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEIGHBOUR_LIMIT = 4'd1;

	localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 9'd1;
	localparam logic [LIMIT_BITS-1:0]     LIMIT_RESET     = 4'd4;

	// All window bits except the centre.
	localparam logic [WIN_BITS-1:0] NEIGHBOUR_MASK = 9'h1EF;

	// True when the centre cell is occupied and has fewer than limit occupied neighbours.
	function automatic logic cell_counts(logic [WIN_BITS-1:0] win,
			logic [LIMIT_BITS-1:0] limit);
		logic [WIN_BITS-1:0] nb;
		logic [LIMIT_BITS-1:0] n;
		nb = win & NEIGHBOUR_MASK;
		n = '0;
		for (int b = 0; b < WIN_BITS; b++) begin
			n = n + LIMIT_BITS'(nb[b]);
		end
		return win[4] && (n < limit);
	endfunction

endpackage

// ===== rtl/grid_sparse_neighbour_counter.sv =====
// Top level: streaming 3x3 neighbourhood counter of sparse occupied grid cells.
//
// Cells arrive in raster order, one byte per item on the cell channel; a byte equal to '@'
// marks an occupied cell. The two previous rows live in one line memory (two bits per column,
// MAX_WIDTH entries, registered synchronous read), and a 3x3 window of registers slides along
// the current row. Each column costs one read and one write-back of that memory, so the block
// takes one cell per clock while streaming; a write and a read of the same column in the same
// cycle (row width one) are resolved by forwarding the written value. Every occupied cell whose
// occupied neighbours number fewer than neighbour_limit adds one to a saturating total;
// neighbours outside the grid count as empty. After the item that carries final_cell the block
// stalls its input and feeds itself empty cells: the rest of the current row plus one whole
// row, one per clock, then drains the pipeline and hands the total to the output register
// (later while an earlier total still waits there). A clearing pass then writes zero to all
// MAX_WIDTH line memory entries, one per clock, before the next grid may start. The same
// clearing pass runs after reset, with cell_stall high. Write row_width and neighbour_limit
// through the configuration port only between grids, while no cell is in flight.
module grid_sparse_neighbour_counter #(
	parameter int MAX_WIDTH  = gsnc_pkg::DEF_MAX_WIDTH,
	parameter int TOTAL_BITS = gsnc_pkg::DEF_TOTAL_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// cell channel
	input  logic                                 cell_valid,
	output logic                                 cell_stall,
	input  logic [gsnc_pkg::CELL_BITS-1:0]       cell_byte,
	input  logic                                 final_cell,
	// total channel
	output logic                                 total_valid,
	input  logic                                 total_stall,
	output logic [gsnc_pkg::OUT_BITS-1:0]        sparse_total,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gsnc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [gsnc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	// column index, live width (holds MAX_WIDTH), compare width, total widths
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (LW > gsnc_pkg::ROW_WIDTH_BITS) ? LW : gsnc_pkg::ROW_WIDTH_BITS;
	localparam int TW = TOTAL_BITS;
	localparam int EW = (TW > gsnc_pkg::OUT_BITS) ? TW : gsnc_pkg::OUT_BITS;
	localparam logic [TW-1:0] TOTAL_MAX = {TW{1'b1}};
	localparam logic [CW-1:0] LAST_COL  = CW'(MAX_WIDTH - 1);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_DRAIN,
		ST_CLEAR
	} state_t;

	state_t state_q;
	logic   two_rows_q;
	logic [CW-1:0] clr_q;
	logic   total_valid_q;
	logic [gsnc_pkg::OUT_BITS-1:0] sparse_total_q;

	// configuration registers
	logic [gsnc_pkg::ROW_WIDTH_BITS-1:0] row_width_q;
	logic [gsnc_pkg::LIMIT_BITS-1:0]     limit_q;

	// stream state
	logic [CW-1:0]                 col_q;
	logic [gsnc_pkg::WIN_BITS-1:0] window_q;
	logic [1:0]                    rows_seen_q;
	logic [TW-1:0]                 total_q;

	// line memory: bit 0 holds the row two above, bit 1 the previous row
	logic [1:0] line_mem [MAX_WIDTH];
	logic [1:0] mem_rd_s1;
	logic       mem_we;
	logic [CW-1:0] mem_wa;
	logic [1:0] mem_wd;

	// stage 1 registers, aligned with the memory read data
	logic          valid_s1;
	logic          occ_s1;
	logic [CW-1:0] col_s1;
	logic          row_end_s1;
	logic          fwd_hit_s1;
	logic [1:0]    fwd_s1;

	logic accept_cell;
	logic step;
	logic step_occ;
	logic [LW-1:0] live_w;
	logic [XW-1:0] rw_x;
	logic [LW-1:0] col_inc;
	logic row_end;
	logic emit;

	logic [1:0] line_cur;
	logic [gsnc_pkg::WIN_BITS-1:0] win_new;
	logic judge_a;
	logic judge_b;
	logic [1:0] inc;
	logic [TW:0] sum;
	logic [TW-1:0] total_next;
	logic [EW-1:0] total_ext;

	assign cfg_ready    = 1'b1;
	assign cell_stall   = (state_q != ST_RUN);
	assign total_valid  = total_valid_q;
	assign sparse_total = sparse_total_q;

	assign accept_cell = cell_valid && !cell_stall;
	// a step is a real cell or an empty cell injected during the flush
	assign step     = accept_cell || (state_q == ST_FLUSH);
	assign step_occ = accept_cell && (cell_byte == gsnc_pkg::OCCUPIED_CHAR);

	// clamp the width register into 1..MAX_WIDTH
	assign rw_x = XW'(row_width_q);
	always_comb begin
		if (row_width_q == '0) begin
			live_w = LW'(1);
		end else if (rw_x > XW'(MAX_WIDTH)) begin
			live_w = LW'(MAX_WIDTH);
		end else begin
			live_w = LW'(rw_x);
		end
	end

	// a row ends when the next column would reach the width (also after a width cut)
	assign col_inc = LW'(col_q) + LW'(1);
	assign row_end = (col_inc >= live_w);

	// output slot free and pipeline empty: hand over the total and start clearing
	assign emit = (state_q == ST_DRAIN) && !valid_s1 && (!total_valid_q || !total_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= gsnc_pkg::ROW_WIDTH_RESET;
			limit_q     <= gsnc_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gsnc_pkg::REG_ROW_WIDTH: begin
					row_width_q <= cfg_data[gsnc_pkg::ROW_WIDTH_BITS-1:0];
				end
				gsnc_pkg::REG_NEIGHBOUR_LIMIT: begin
					limit_q <= cfg_data[gsnc_pkg::LIMIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer: stream, flush, drain, clear; also holds the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			two_rows_q     <= 1'b0;
			clr_q          <= '0;
			total_valid_q  <= 1'b0;
			sparse_total_q <= '0;
		end else begin
			// raise the output valid on hand-over, drop it once the total is taken
			if (emit) begin
				total_valid_q <= 1'b1;
			end else if (total_valid_q && !total_stall) begin
				total_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (accept_cell && final_cell) begin
						// finish a partial row first, then one empty row
						two_rows_q <= !row_end;
						state_q    <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (row_end) begin
						if (two_rows_q) begin
							two_rows_q <= 1'b0;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (emit) begin
						sparse_total_q <= total_ext[gsnc_pkg::OUT_BITS-1:0];
						clr_q          <= '0;
						state_q        <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == LAST_COL) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// memory write port: clearing pass or write-back of the cell in stage 1
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = 2'b00;
		end else begin
			mem_we = valid_s1;
			mem_wa = col_s1;
			mem_wd = {occ_s1, line_cur[1]};
		end
	end

	// line memory, read every cycle at the current column
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_wa] <= mem_wd;
		end
		mem_rd_s1 <= line_mem[col_q];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
		end else begin
			valid_s1 <= step;
			if (emit) begin
				col_q <= '0;
			end else if (step) begin
				col_q <= row_end ? '0 : CW'(col_inc);
			end
		end
	end

	// stage 1 payload; forward a write-back to the column read in the same cycle
	always_ff @(posedge clk) begin
		if (step) begin
			occ_s1     <= step_occ;
			col_s1     <= col_q;
			row_end_s1 <= row_end;
			fwd_hit_s1 <= valid_s1 && (col_s1 == col_q);
			fwd_s1     <= mem_wd;
		end
	end

	// stage 2: build the window column, judge the centre (and the edge cell at row end)
	assign line_cur = fwd_hit_s1 ? fwd_s1 : mem_rd_s1;
	assign win_new  = {occ_s1, line_cur[1], line_cur[0], window_q[8:3]};
	assign judge_a  = (rows_seen_q != 2'd0) && gsnc_pkg::cell_counts(win_new, limit_q);
	assign judge_b  = row_end_s1 && (rows_seen_q != 2'd0)
		&& gsnc_pkg::cell_counts({3'b000, win_new[8:3]}, limit_q);
	assign inc      = 2'(judge_a) + 2'(judge_b);
	assign sum      = (TW + 1)'(total_q) + (TW + 1)'(inc);
	assign total_next = (sum > (TW + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TW-1:0];
	assign total_ext  = EW'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			rows_seen_q <= '0;
			total_q     <= '0;
		end else if (emit) begin
			window_q    <= '0;
			rows_seen_q <= '0;
			total_q     <= '0;
		end else if (valid_s1) begin
			total_q <= total_next;
			if (row_end_s1) begin
				window_q <= '0;
				if (rows_seen_q != 2'd2) begin
					rows_seen_q <= rows_seen_q + 2'd1;
				end
			end else begin
				window_q <= win_new;
			end
		end
	end

endmodule

// ===== rtl/gsnc_checker.sv =====
// Port checker of the grid sparse neighbour counter, bound to the top level.
`include "grid_sparse_neighbour_counter_defines.svh"

module gsnc_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cell_valid,
	input logic                             cell_stall,
	input logic                             final_cell,
	input logic                             total_valid,
	input logic                             total_stall,
	input logic [gsnc_pkg::OUT_BITS-1:0]    sparse_total
);

	// a stalled total holds
	`GSNC_ASSERT_NEXT(a_total_hold, clk, arst_n, total_valid && total_stall,
		total_valid && $stable(sparse_total))

	// the last cell of a grid starts the flush, which stalls the input
	`GSNC_ASSERT_NEXT(a_final_stalls, clk, arst_n, cell_valid && !cell_stall && final_cell,
		cell_stall)

	// a total appears only once the input is already stalled
	`GSNC_ASSERT_SAME(a_total_after_flush, clk, arst_n, $rose(total_valid), $past(cell_stall))

	// the line memory clears while a new total is shown
	`GSNC_ASSERT_SAME(a_total_with_clear, clk, arst_n, $rose(total_valid), cell_stall)

endmodule

bind grid_sparse_neighbour_counter gsnc_port_checker u_gsnc_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cell_valid   (cell_valid),
	.cell_stall   (cell_stall),
	.final_cell   (final_cell),
	.total_valid  (total_valid),
	.total_stall  (total_stall),
	.sparse_total (sparse_total)
);
